/* design/goch_pkg.sv */
// Shared types and constants for the gradient orientation cell histogram core.
package goch_pkg;

   localparam int GRAD_WIDTH          = 16;
   localparam int NUM_BINS            = 8;
   localparam int COUNT_WIDTH         = 8;
   localparam int BIN_W               = $clog2(NUM_BINS);
   localparam int ROW_W               = NUM_BINS * COUNT_WIDTH;
   localparam int CELL_SIDE_DEF       = 4;
   localparam int CELLS_PER_SIDE_DEF  = 4;

   // tan(pi/8) with 32 fraction bits
   localparam logic [31:0] TAN_PI_8_Q32 = 32'h6A09_E668;

   // sector offsets from bin 4
   localparam logic [BIN_W-1:0] SECT_AXIS_POS = 3'd0;
   localparam logic [BIN_W-1:0] SECT_DIAG_POS = 3'd1;
   localparam logic [BIN_W-1:0] SECT_AXIS_Y   = 3'd2;
   localparam logic [BIN_W-1:0] SECT_DIAG_NEG = 3'd3;
   localparam logic [BIN_W-1:0] SECT_AXIS_NEG = 3'd4;
   localparam logic [BIN_W-1:0] BIN_CENTER    = 3'd4;

   typedef struct packed {
      logic signed [GRAD_WIDTH-1:0] grad_x;
      logic signed [GRAD_WIDTH-1:0] grad_y;
      logic [3:0]                   column;
      logic [3:0]                   row;
      logic                         end_of_region;
   } req_type;

   typedef struct packed {
      logic [3:0]       cell_index;
      logic [ROW_W-1:0] bin_counts;
      logic             last_cell;
   } rsp_type;

   // one store access: a pixel update or a drain read that also clears the row
   typedef struct packed {
      logic             en;
      logic             drain;
      logic [BIN_W-1:0] bin;
   } store_req_type;

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_FLUSH,
      ST_DRAIN
   } state_type;

endpackage

/* design/goch_sector.sv */
// Orientation sector classifier: gradient pair to histogram bin.
module goch_sector (
   input  logic signed [goch_pkg::GRAD_WIDTH-1:0] grad_x,
   input  logic signed [goch_pkg::GRAD_WIDTH-1:0] grad_y,
   output logic        [goch_pkg::BIN_W-1:0]      bin
);

   localparam int GW     = goch_pkg::GRAD_WIDTH;
   localparam int PROD_W = GW + 32;

   logic          x_neg, y_neg;
   logic [GW-1:0] mag_x, mag_y;
   logic [PROD_W-1:0] shift_x, shift_y, prod_x, prod_y;
   logic          near_x, near_y;
   logic [goch_pkg::BIN_W-1:0] sect;

   assign x_neg = grad_x[GW-1];
   assign y_neg = grad_y[GW-1];
   // -min wraps to the same bit pattern, which is its correct unsigned magnitude
   assign mag_x = x_neg ? GW'(-grad_x) : GW'(grad_x);
   assign mag_y = y_neg ? GW'(-grad_y) : GW'(grad_y);

   assign shift_y = {mag_y, 32'd0};
   assign shift_x = {mag_x, 32'd0};
   assign prod_x  = PROD_W'(mag_x) * PROD_W'(goch_pkg::TAN_PI_8_Q32);
   assign prod_y  = PROD_W'(mag_y) * PROD_W'(goch_pkg::TAN_PI_8_Q32);

   // ties follow the half-open sector rule: they break by quadrant
   assign near_x = (shift_y < prod_x) || ((shift_y == prod_x) && ((!x_neg) == y_neg));
   assign near_y = (shift_x < prod_y) || ((shift_x == prod_y) && (x_neg == y_neg));

   always_comb begin
      if (near_x) begin
         sect = x_neg ? goch_pkg::SECT_AXIS_NEG : goch_pkg::SECT_AXIS_POS;
      end else if (near_y) begin
         sect = goch_pkg::SECT_AXIS_Y;
      end else begin
         sect = x_neg ? goch_pkg::SECT_DIAG_NEG : goch_pkg::SECT_DIAG_POS;
      end
      if ((mag_x == '0) && (mag_y == '0)) begin
         bin = goch_pkg::BIN_CENTER;
      end else if (y_neg) begin
         bin = goch_pkg::BIN_CENTER - sect;
      end else begin
         bin = goch_pkg::BIN_CENTER + sect;
      end
   end

endmodule

/* design/goch_store.sv */
// Histogram store: one row of packed bin counts per cell, read-modify-write.
module goch_store #(
   parameter int NUM_CELLS = goch_pkg::CELLS_PER_SIDE_DEF * goch_pkg::CELLS_PER_SIDE_DEF,
   parameter int CELL_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  goch_pkg::store_req_type       acc,
   input  logic [CELL_W-1:0]             acc_cell,
   output logic [goch_pkg::ROW_W-1:0]    rd_row
);

   localparam int CW = goch_pkg::COUNT_WIDTH;

   logic [goch_pkg::ROW_W-1:0] mem [NUM_CELLS];
   logic [NUM_CELLS-1:0]       row_valid_ff;

   logic [goch_pkg::ROW_W-1:0] rd_data_ff;
   logic                       rd_hit_ff;

   logic                       s2_upd_ff;
   logic [CELL_W-1:0]          s2_cell_ff;
   logic [goch_pkg::BIN_W-1:0] s2_bin_ff;

   logic                       s3_valid_ff;
   logic [CELL_W-1:0]          s3_cell_ff;
   logic [goch_pkg::ROW_W-1:0] s3_row_ff;

   logic [goch_pkg::ROW_W-1:0] cur_row, new_row;

   assign rd_row = rd_hit_ff ? rd_data_ff : '0;

   // the write of the previous update lands on the edge this row was read
   assign cur_row = (s3_valid_ff && (s3_cell_ff == s2_cell_ff)) ? s3_row_ff : rd_row;

   always_comb begin
      new_row = cur_row;
      for (int b = 0; b < goch_pkg::NUM_BINS; b++) begin
         if (goch_pkg::BIN_W'(b) == s2_bin_ff) begin
            new_row[b*CW +: CW] = cur_row[b*CW +: CW] + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc.en) begin
         rd_data_ff <= mem[acc_cell];
      end
      if (s2_upd_ff) begin
         mem[s2_cell_ff] <= new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_hit_ff    <= 1'b0;
         s2_upd_ff    <= 1'b0;
         s3_valid_ff  <= 1'b0;
      end else begin
         if (acc.en) begin
            rd_hit_ff <= row_valid_ff[acc_cell];
         end
         if (acc.en && acc.drain) begin
            row_valid_ff[acc_cell] <= 1'b0;
         end
         if (s2_upd_ff) begin
            row_valid_ff[s2_cell_ff] <= 1'b1;
         end
         s2_upd_ff   <= acc.en && !acc.drain;
         s3_valid_ff <= s2_upd_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_cell_ff <= acc_cell;
      s2_bin_ff  <= acc.bin;
      s3_cell_ff <= s2_cell_ff;
      s3_row_ff  <= new_row;
   end

endmodule

/* design/gradient_orientation_cell_histogram_core.sv */
// Top level of the gradient orientation cell histogram core.
//
//   channel   ports                         handshake
//   -------   ---------------------------   ---------------------------------
//   pixel     start, busy, req_data         taken when start && !busy
//   result    rsp_strobe, rsp_data          one cycle per result, no stall
//
// One pixel per cycle while busy is low: classify (a constant multiply and compare
// per axis), read the cell row, then increment and write back with forwarding
// between neighbors. After an end_of_region pixel, busy stays high through
// ST_FLUSH, while that pixel lands in the store, and through ST_DRAIN, with one
// store read per cell result. Results follow in consecutive cycles, cell 0 first.
// Reset is synchronous and empties the store at once through per-row valid bits.
module gradient_orientation_cell_histogram_core #(
   parameter int CELL_SIDE      = goch_pkg::CELL_SIDE_DEF,
   parameter int CELLS_PER_SIDE = goch_pkg::CELLS_PER_SIDE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  goch_pkg::req_type req_data,
   output logic              rsp_strobe,
   output goch_pkg::rsp_type rsp_data
);

   localparam int NUM_CELLS = CELLS_PER_SIDE * CELLS_PER_SIDE;
   localparam int CELL_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(NUM_CELLS - 1);

   goch_pkg::state_type state_ff, state_in;

   logic              accept;
   logic [3:0]        cell_col, cell_row;
   logic [7:0]        cell_lin;
   logic              in_region;

   logic              s1_valid_ff, s1_eor_ff, s1_in_ff;
   logic [CELL_W-1:0] s1_cell_ff;
   logic signed [goch_pkg::GRAD_WIDTH-1:0] s1_gx_ff, s1_gy_ff;
   logic              s2_eor_ff;

   logic [CELL_W-1:0] cnt_ff, cnt_in;
   logic              rsp_strobe_ff;
   logic [CELL_W-1:0] rsp_cell_ff;
   logic              rsp_last_ff;

   logic [goch_pkg::BIN_W-1:0] pix_bin;
   goch_pkg::store_req_type    acc;
   logic [CELL_W-1:0]          acc_cell;
   logic [goch_pkg::ROW_W-1:0] rd_row;

   // pixel coordinate to cell coordinate: count the cell edges at or below it
   function automatic logic [3:0] cell_coord(input logic [3:0] pos);
      logic [3:0] q;
      q = '0;
      for (int k = 1; k < 16; k++) begin
         if (int'(pos) >= k * CELL_SIDE) begin
            q = q + 4'd1;
         end
      end
      return q;
   endfunction

   assign accept    = start && !busy;
   assign cell_col  = cell_coord(req_data.column);
   assign cell_row  = cell_coord(req_data.row);
   assign in_region = (cell_col < 4'(CELLS_PER_SIDE)) && (cell_row < 4'(CELLS_PER_SIDE));
   assign cell_lin  = 8'(cell_row) * 8'(CELLS_PER_SIDE) + 8'(cell_col);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= goch_pkg::ST_COLLECT;
         cnt_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         s1_eor_ff     <= 1'b0;
         s2_eor_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         s1_valid_ff   <= accept;
         s1_eor_ff     <= accept && req_data.end_of_region;
         s2_eor_ff     <= s1_valid_ff && s1_eor_ff;
         rsp_strobe_ff <= (state_ff == goch_pkg::ST_DRAIN);
      end
   end

   always_ff @(posedge clock) begin
      s1_in_ff    <= in_region;
      s1_cell_ff  <= CELL_W'(cell_lin);
      s1_gx_ff    <= req_data.grad_x;
      s1_gy_ff    <= req_data.grad_y;
      rsp_cell_ff <= cnt_ff;
      rsp_last_ff <= (cnt_ff == LAST_CELL);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         goch_pkg::ST_COLLECT: begin
            if (accept && req_data.end_of_region) begin
               state_in = goch_pkg::ST_FLUSH;
            end
         end
         goch_pkg::ST_FLUSH: begin
            if (s2_eor_ff) begin
               state_in = goch_pkg::ST_DRAIN;
            end
         end
         goch_pkg::ST_DRAIN: begin
            if (cnt_ff == LAST_CELL) begin
               state_in = goch_pkg::ST_COLLECT;
            end
         end
         default: state_in = goch_pkg::ST_COLLECT;
      endcase
   end

   // outputs and store access
   always_comb begin
      busy      = 1'b1;
      cnt_in    = '0;
      acc.en    = s1_valid_ff && s1_in_ff;
      acc.drain = 1'b0;
      acc.bin   = pix_bin;
      acc_cell  = s1_cell_ff;
      case (state_ff)
         goch_pkg::ST_COLLECT: begin
            busy = 1'b0;
         end
         goch_pkg::ST_FLUSH: begin
            busy = 1'b1;
         end
         goch_pkg::ST_DRAIN: begin
            acc.en    = 1'b1;
            acc.drain = 1'b1;
            acc_cell  = cnt_ff;
            cnt_in    = cnt_ff + CELL_W'(1);
         end
         default: busy = 1'b1;
      endcase
   end

   goch_sector u_sector (
      .grad_x (s1_gx_ff),
      .grad_y (s1_gy_ff),
      .bin    (pix_bin)
   );

   goch_store #(
      .NUM_CELLS (NUM_CELLS),
      .CELL_W    (CELL_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .acc      (acc),
      .acc_cell (acc_cell),
      .rd_row   (rd_row)
   );

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_data.cell_index = 4'(rsp_cell_ff);
   assign rsp_data.bin_counts = rd_row;
   assign rsp_data.last_cell  = rsp_last_ff;

endmodule

/* design/goch_checker.sv */
// Port-level checks on the result burst of the histogram core, with its bind.
module goch_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input goch_pkg::req_type req_data,
   input logic              rsp_strobe,
   input goch_pkg::rsp_type rsp_data
);

   // a region burst never breaks before its last cell
   a_burst_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_cell |=> rsp_strobe)
      else $error("result burst broken before last cell");

   a_burst_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last_cell |=> !rsp_strobe)
      else $error("result after last cell");

   a_cell_order: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_cell |=>
         rsp_data.cell_index == 4'($past(rsp_data.cell_index) + 4'd1))
      else $error("cell results out of order");

   a_eor_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.end_of_region |=> busy)
      else $error("not busy after end of region item");

   a_idle_no_result: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !rsp_strobe || rsp_data.last_cell)
      else $error("mid-burst result while accepting items");

endmodule

bind gradient_orientation_cell_histogram_core goch_checker u_goch_checker (.*);

/* bench/gradient_orientation_cell_histogram_core_test.sv */
// Self-checking bench for the gradient orientation cell histogram core.
module gradient_orientation_cell_histogram_core_test;
   import goch_pkg::*;

   localparam int CELL_SIDE      = CELL_SIDE_DEF;
   localparam int CELLS_PER_SIDE = CELLS_PER_SIDE_DEF;
   localparam int NUM_CELLS      = CELLS_PER_SIDE * CELLS_PER_SIDE;

   class histogram_scoreboard;
      logic [COUNT_WIDTH-1:0] cell_bins [NUM_CELLS][NUM_BINS];
      rsp_type                pending_cells [$];
      int                     errors;

      function new();
         errors = 0;
         clear_bins();
      endfunction

      function void clear_bins();
         foreach (cell_bins[c, b]) cell_bins[c][b] = '0;
      endfunction

      function logic [63:0] grad_mag(logic signed [GRAD_WIDTH-1:0] g);
         logic [GRAD_WIDTH-1:0] v;
         v = g[GRAD_WIDTH-1] ? (~g + 1'b1) : g;
         return {{(64-GRAD_WIDTH){1'b0}}, v};
      endfunction

      // bins the pixel; on end of region queues every cell histogram and clears
      function void note_pixel(req_type px);
         logic [63:0]      ax, ay, tan_q;
         logic             xneg, yneg, near_x, near_y;
         logic [BIN_W-1:0] sect, bin;
         int               ccol, crow, cell_num;
         rsp_type          cell_out;
         ax    = grad_mag(px.grad_x);
         ay    = grad_mag(px.grad_y);
         xneg  = px.grad_x[GRAD_WIDTH-1];
         yneg  = px.grad_y[GRAD_WIDTH-1];
         tan_q = {32'd0, TAN_PI_8_Q32};
         if (ax == 0 && ay == 0) begin
            bin = BIN_CENTER;
         end else begin
            // ties follow the [lower, upper) sector rule
            near_x = ((ay << 32) < tan_q * ax) ||
                     (((ay << 32) == tan_q * ax) && ((!xneg) == yneg));
            near_y = ((ax << 32) < tan_q * ay) ||
                     (((ax << 32) == tan_q * ay) && ((!xneg) == (!yneg)));
            if (near_x)
               sect = xneg ? SECT_AXIS_NEG : SECT_AXIS_POS;
            else if (near_y)
               sect = SECT_AXIS_Y;
            else
               sect = xneg ? SECT_DIAG_NEG : SECT_DIAG_POS;
            bin = yneg ? BIN_CENTER - sect : BIN_CENTER + sect;
         end
         ccol = px.column / CELL_SIDE;
         crow = px.row / CELL_SIDE;
         if (ccol < CELLS_PER_SIDE && crow < CELLS_PER_SIDE) begin
            cell_num = crow * CELLS_PER_SIDE + ccol;
            cell_bins[cell_num][bin] = cell_bins[cell_num][bin] + 1'b1;
         end
         if (px.end_of_region) begin
            for (int c = 0; c < NUM_CELLS; c++) begin
               cell_out.cell_index = 4'(c);
               for (int b = 0; b < NUM_BINS; b++)
                  cell_out.bin_counts[COUNT_WIDTH*b +: COUNT_WIDTH] = cell_bins[c][b];
               cell_out.last_cell = (c == NUM_CELLS - 1);
               pending_cells.insert(pending_cells.size(), cell_out);
            end
            clear_bins();
         end
      endfunction

      function void check_cell(rsp_type got);
         rsp_type want;
         if (pending_cells.size() == 0) begin
            $display("%0t: unexpected cell result: expected none, got %h", $time, got);
            errors++;
            return;
         end
         want = pending_cells.pop_front();
         if (got.cell_index !== want.cell_index) begin
            $display("%0t: cell_index mismatch: expected %0d, got %0d",
                     $time, want.cell_index, got.cell_index);
            errors++;
         end
         if (got.bin_counts !== want.bin_counts) begin
            $display("%0t: bin_counts mismatch (cell %0d): expected %h, got %h",
                     $time, want.cell_index, want.bin_counts, got.bin_counts);
            errors++;
         end
         if (got.last_cell !== want.last_cell) begin
            $display("%0t: last_cell mismatch (cell %0d): expected %b, got %b",
                     $time, want.cell_index, want.last_cell, got.last_cell);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   histogram_scoreboard board;
   int                  sender_idle_pct;

   gradient_orientation_cell_histogram_core #(
      .CELL_SIDE      (CELL_SIDE),
      .CELLS_PER_SIDE (CELLS_PER_SIDE)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) board.note_pixel(req_data);
         if (rsp_strobe) board.check_cell(rsp_data);
      end
   end

   function automatic req_type pixel(int gx, int gy, int col, int row, bit eor);
      req_type px;
      px.grad_x        = GRAD_WIDTH'(gx);
      px.grad_y        = GRAD_WIDTH'(gy);
      px.column        = 4'(col);
      px.row           = 4'(row);
      px.end_of_region = eor;
      return px;
   endfunction

   // returns at the edge that takes the item; start is left high
   task automatic send_pixel(req_type px);
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (busy);
   endtask

   // regions of random length, each closed by an end-of-region pixel
   task automatic stream_regions(int idle_pct, int n_items);
      int          sent, len, ax, ay, gx, gy, col, row, tmp;
      int          last_col, last_row;
      logic [63:0] edge_ay;
      sender_idle_pct = idle_pct;
      sent     = 0;
      last_col = 0;
      last_row = 0;
      while (sent < n_items) begin
         len = $urandom_range(1, 24);
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(3))
               0: begin
                  gx = $signed(16'($urandom));
                  gy = $signed(16'($urandom));
               end
               1: begin
                  gx = $urandom_range(16) - 8;
                  gy = $urandom_range(16) - 8;
               end
               2: begin
                  tmp = $urandom_range(3);
                  gx = (tmp == 0) ? -32768 : (tmp == 1) ? 32767 : (tmp == 2) ? 0 : -32767;
                  tmp = $urandom_range(3);
                  gy = (tmp == 0) ? -32768 : (tmp == 1) ? 32767 : (tmp == 2) ? 0 : -32767;
               end
               default: begin
                  // straddle a sector boundary
                  ax      = $urandom_range(1, 32767);
                  edge_ay = (64'(ax) * {32'd0, TAN_PI_8_Q32}) >> 32;
                  ay      = int'(edge_ay) + $urandom_range(2) - 1;
                  if (ay < 0) ay = 0;
                  if ($urandom_range(1)) begin
                     tmp = ax;
                     ax  = ay;
                     ay  = tmp;
                  end
                  gx = $urandom_range(1) ? -ax : ax;
                  gy = $urandom_range(1) ? -ay : ay;
               end
            endcase
            case ($urandom_range(3))
               0, 1: begin
                  col = $urandom_range(15);
                  row = $urandom_range(15);
               end
               2: begin
                  col = last_col;
                  row = last_row;
               end
               default: begin
                  col = (last_col & 12) | $urandom_range(3);
                  row = (last_row & 12) | $urandom_range(3);
               end
            endcase
            last_col = col;
            last_row = row;
            send_pixel(pixel(gx, gy, col, row, i == len - 1));
            sent++;
         end
      end
   endtask

   initial begin
      board           = new();
      sender_idle_pct = 0;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // axes, diagonals, extremes, zero gradient, both sides of sector edges
      send_pixel(pixel(0, 0, 0, 0, 1'b0));
      send_pixel(pixel(32767, 0, 0, 0, 1'b0));
      send_pixel(pixel(-32768, 0, 1, 2, 1'b0));
      send_pixel(pixel(0, 32767, 15, 0, 1'b0));
      send_pixel(pixel(0, -32768, 15, 0, 1'b0));
      send_pixel(pixel(100, 100, 0, 15, 1'b0));
      send_pixel(pixel(-100, 100, 5, 6, 1'b0));
      send_pixel(pixel(-100, -100, 5, 6, 1'b0));
      send_pixel(pixel(100, -100, 5, 6, 1'b0));
      send_pixel(pixel(-32768, -32768, 8, 11, 1'b0));
      send_pixel(pixel(32767, -32768, 12, 3, 1'b0));
      send_pixel(pixel(-32767, 32767, 3, 12, 1'b0));
      send_pixel(pixel(1000, 414, 10, 10, 1'b0));
      send_pixel(pixel(1000, 415, 10, 10, 1'b0));
      send_pixel(pixel(-1000, -414, 10, 10, 1'b0));
      send_pixel(pixel(-1000, -415, 10, 10, 1'b0));
      send_pixel(pixel(414, 1000, 7, 9, 1'b0));
      send_pixel(pixel(415, 1000, 7, 9, 1'b0));
      send_pixel(pixel(-414, -1000, 7, 9, 1'b0));
      send_pixel(pixel(-415, 1000, 7, 9, 1'b0));
      send_pixel(pixel(1, -1, 15, 15, 1'b1));
      // a region of one pixel, right behind the previous one
      send_pixel(pixel(-1, 0, 4, 4, 1'b1));

      stream_regions(0, 48);
      stream_regions(63, 48);
      stream_regions(38, 48);
      start <= 1'b0;

      while (board.pending_cells.size() != 0) @(posedge clock);
      repeat (NUM_CELLS + 8) @(posedge clock);
      if (board.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #200000;
      $display("tb: failure");
      $finish;
   end

endmodule

/* gradient_orientation_cell_histogram_core.f */
design/goch_pkg.sv
design/goch_sector.sv
design/goch_store.sv
design/gradient_orientation_cell_histogram_core.sv
design/goch_checker.sv
bench/gradient_orientation_cell_histogram_core_test.sv
